### rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL; clk and rst_n are taken from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fbpa_pkg.sv
// Shared widths, request codes and controller/datapath interface types for the block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int CNT_W      = 9;
    localparam int IDX_OUT_W  = 8;
    localparam int DEF_BLOCKS = 256;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic init_start;
        logic init_step;
        logic alloc_rd;
        logic alloc_done;
        logic free_link;
        logic free_null;
        logic reject;
    } cmd_t;

    typedef struct packed {
        logic head_null;
        logic free_valid;
        logic init_last;
    } status_t;

endpackage

### rtl/core/fbpa_ctrl.sv
// Sequencing state machine of the block pool allocator.
`timescale 1ns / 1ps

module fbpa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             req_type,
    input  logic             cfg_we,
    input  fbpa_pkg::status_t status,
    output fbpa_pkg::cmd_t    cmd,
    output logic             busy
);
    import fbpa_pkg::*;

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_ALLOC = 2'd2;
    localparam logic [1:0] ST_FREE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        if (cfg_we)
        begin
            // A new block count restarts the list rebuild from any state.
            cmd.init_start = 1'b1;
            state_next     = ST_INIT;
        end
        else
        begin
            unique case (state_reg)
                ST_INIT:
                begin
                    cmd.init_step = 1'b1;
                    if (status.init_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (req_type == REQ_ALLOC)
                        begin
                            if (status.head_null)
                            begin
                                cmd.reject = 1'b1;
                            end
                            else
                            begin
                                cmd.alloc_rd = 1'b1;
                                state_next   = ST_ALLOC;
                            end
                        end
                        else
                        begin
                            if (status.free_valid)
                            begin
                                cmd.free_link = 1'b1;
                                state_next    = ST_FREE;
                            end
                            else
                            begin
                                cmd.reject = 1'b1;
                            end
                        end
                    end
                end
                ST_ALLOC:
                begin
                    cmd.alloc_done = 1'b1;
                    state_next     = ST_IDLE;
                end
                ST_FREE:
                begin
                    cmd.free_null = 1'b1;
                    state_next    = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### rtl/core/fbpa_datapath.sv
// Link memory, head, tail and count registers and result registers of the block pool allocator.
`timescale 1ns / 1ps

module fbpa_datapath #(
    parameter int BLOCKS = fbpa_pkg::DEF_BLOCKS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [fbpa_pkg::CNT_W-1:0]       cfg_data,
    input  logic [fbpa_pkg::IDX_OUT_W-1:0]   block_index,
    input  fbpa_pkg::cmd_t                   cmd,
    output fbpa_pkg::status_t                status,
    output logic                             done,
    output logic                             ok,
    output logic [fbpa_pkg::IDX_OUT_W-1:0]   block_index_out
);
    import fbpa_pkg::*;

    localparam int IDX_W     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int LINK_W    = $clog2(BLOCKS + 1);
    localparam int CMP_W     = (LINK_W > CNT_W) ? LINK_W : CNT_W;
    localparam int CNT_MAX_I = (BLOCKS < 511) ? BLOCKS : 511;
    localparam int CNT_RST_I = (BLOCKS < 256) ? BLOCKS : 256;

    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(CNT_MAX_I);
    localparam logic [CNT_W-1:0]  CNT_RST   = CNT_W'(CNT_RST_I);
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(BLOCKS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(BLOCKS - 1);

    logic [LINK_W-1:0] link_mem [BLOCKS];

    logic [CNT_W-1:0]     count_reg;
    logic [LINK_W-1:0]    head_reg;
    logic [IDX_W-1:0]     tail_reg;
    logic [IDX_W-1:0]     ptr_reg;
    logic [IDX_OUT_W-1:0] idx_reg;
    logic [LINK_W-1:0]    rd_reg;
    logic                 done_reg;
    logic                 ok_reg;
    logic [IDX_OUT_W-1:0] out_reg;

    logic [CNT_W-1:0]  count_next;
    logic [CMP_W-1:0]  ptr_succ;
    logic [LINK_W-1:0] init_link;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LINK_W-1:0] mem_wdata;

    // Written values outside 1 to the smaller of BLOCKS and 511 are pulled to the nearest end.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            count_next = CNT_W'(1);
        end
        else if (cfg_data > CNT_MAX)
        begin
            count_next = CNT_MAX;
        end
        else
        begin
            count_next = cfg_data;
        end
    end

    assign ptr_succ  = CMP_W'(ptr_reg) + CMP_W'(1);
    assign init_link = (ptr_succ < CMP_W'(count_reg)) ? LINK_W'(ptr_succ) : LINK_NULL;

    assign status.head_null  = (head_reg >= LINK_NULL);
    assign status.free_valid = ({1'b0, block_index} < count_reg);
    assign status.init_last  = (ptr_reg == LAST_IDX);

    // One write port: the rebuild pass, the old tail's link, or the freed block's null link.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = init_link;
        if (cmd.init_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.free_link && !status.head_null)
        begin
            mem_we    = 1'b1;
            mem_waddr = tail_reg;
            mem_wdata = LINK_W'(block_index);
        end
        else if (cmd.free_null)
        begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(idx_reg);
            mem_wdata = LINK_NULL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.alloc_rd)
        begin
            rd_reg <= link_mem[head_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_RST;
            head_reg  <= '0;
            tail_reg  <= IDX_W'(CNT_RST - CNT_W'(1));
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.alloc_done | cmd.free_null | cmd.reject;
            if (cmd.init_start)
            begin
                count_reg <= count_next;
                head_reg  <= '0;
                tail_reg  <= IDX_W'(count_next - CNT_W'(1));
                ptr_reg   <= '0;
            end
            else
            begin
                if (cmd.init_step)
                begin
                    ptr_reg <= ptr_reg + IDX_W'(1);
                end
                if (cmd.alloc_done)
                begin
                    head_reg <= rd_reg;
                end
                if (cmd.free_link)
                begin
                    // An empty list restarts at the freed block.
                    if (status.head_null)
                    begin
                        head_reg <= LINK_W'(block_index);
                    end
                    tail_reg <= IDX_W'(block_index);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc_rd || cmd.free_link || cmd.reject)
        begin
            idx_reg <= block_index;
        end
        ok_reg  <= cmd.alloc_done | cmd.free_null;
        out_reg <= cmd.alloc_done ? IDX_OUT_W'(head_reg) : '0;
    end

    assign done            = done_reg;
    assign ok              = ok_reg;
    assign block_index_out = out_reg;

endmodule

### rtl/core/fixed_block_pool_allocator.sv
// Top level of the fixed-size block pool allocator with a linked free list.
//
//  Channel   | Handshake                   | Payload
//  ----------+-----------------------------+-------------------------------
//  request   | start, busy (taken: !busy)  | req_type, block_index
//  result    | done (one-cycle strobe)     | ok, block_index_out
//  config    | cfg_valid, cfg_ready        | cfg_data (block count)
//
// A successful allocate or an accepted free holds busy high in its ALLOC or FREE state and
// strobes done as busy falls. An allocate waits for the registered read of the head's link;
// a free writes the old tail's link, if the list was not empty, and the freed block's null
// link through the one write port. A rejected request strobes done the next cycle and
// leaves busy low. After reset and after every block count write, the link memory is
// rebuilt one entry a cycle with busy high. The result cannot be stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fixed_block_pool_allocator #(
    parameter int BLOCKS = fbpa_pkg::DEF_BLOCKS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic [fbpa_pkg::IDX_OUT_W-1:0] block_index,
    output logic                           done,
    output logic                           ok,
    output logic [fbpa_pkg::IDX_OUT_W-1:0] block_index_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbpa_pkg::CNT_W-1:0]     cfg_data
);
    import fbpa_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    fbpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .cfg_we   (cfg_we),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    fbpa_datapath #(
        .BLOCKS (BLOCKS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_data        (cfg_data),
        .block_index     (block_index),
        .cmd             (cmd),
        .status          (status),
        .done            (done),
        .ok              (ok),
        .block_index_out (block_index_out)
    );

    `ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command at once")
    `ASSERT_NXT(a_accept_progress, start && !busy && !cfg_we, busy || done, "transaction dropped")
    `ASSERT_NXT(a_cfg_rebuild, cfg_we, busy && !done, "no rebuild after a block count write")
    `ASSERT_IMP(a_fail_zero, done && !ok, block_index_out == '0, "failed result with an index")
    `ASSERT_IMP(a_done_cause, done, $past(busy || start), "result strobe without a transaction")

endmodule
